>>> rtl/tlink_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlink_pkg: shared types for the two-wire handshake link
// Phase codes, input request and result layouts.
// ----------------------------------------------------------------------------
package tlink_pkg;

  localparam int ByteW = 8;
  localparam int IdxW  = 3;

  localparam logic [ByteW-1:0] ErrByte  = 8'hFF;
  localparam logic [IdxW-1:0]  LastBit  = 3'd7;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [IdxW-1:0]  bit_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RX_BIT   = 4'd1,
    PH_RX_HOLD1 = 4'd2,
    PH_RX_HOLD0 = 4'd3,
    PH_RX_REL   = 4'd4,
    PH_RX_ERR   = 4'd5,
    PH_TX_DRIVE = 4'd6,
    PH_TX_REL   = 4'd7
  } phase_t;

  typedef struct packed {
    logic  op;
    byte_t send_byte;
    logic  red_level;
    logic  white_level;
  } in_item_t;

  typedef struct packed {
    logic  pull_red;
    logic  pull_white;
    logic  rx_valid;
    byte_t rx_byte;
    logic  rx_error;
    logic  tx_done;
    logic  tx_refused;
    logic  busy_res;
  } out_item_t;

endpackage

>>> rtl/tlink_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlink_in_if: request channel
// Valid/ready channel carrying one line sample and an optional send request.
// ----------------------------------------------------------------------------
interface tlink_in_if;
  logic                valid;
  logic                ready;
  logic                op;
  tlink_pkg::byte_t    send_byte;
  logic                red_level;
  logic                white_level;

  modport source (output valid, output op, output send_byte, output red_level,
                  output white_level, input ready);
  modport sink   (input valid, input op, input send_byte, input red_level,
                  input white_level, output ready);
endinterface

>>> rtl/tlink_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlink_out_if: result channel
// Valid/ready channel carrying line drives and transfer status.
// ----------------------------------------------------------------------------
interface tlink_out_if;
  logic                valid;
  logic                ready;
  logic                pull_red;
  logic                pull_white;
  logic                rx_valid;
  tlink_pkg::byte_t    rx_byte;
  logic                rx_error;
  logic                tx_done;
  logic                tx_refused;
  logic                busy_res;

  modport source (output valid, output pull_red, output pull_white, output rx_valid,
                  output rx_byte, output rx_error, output tx_done, output tx_refused,
                  output busy_res, input ready);
  modport sink   (input valid, input pull_red, input pull_white, input rx_valid,
                  input rx_byte, input rx_error, input tx_done, input tx_refused,
                  input busy_res, output ready);
endinterface

>>> rtl/tlink_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlink_core: link handshake state machine
// Holds phase, bit index and shift register; computes one result per request.
// ----------------------------------------------------------------------------
module tlink_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 spy_only,
  input  tlink_pkg::in_item_t  item,
  output tlink_pkg::out_item_t res
);
  import tlink_pkg::*;

  phase_t   phase_r, phase_nxt;
  bit_idx_t idx_r, idx_nxt;
  byte_t    shift_r, shift_nxt;

  logic  idle_lines;
  logic  rep_valid, rep_err, tx_done, tx_refused;
  byte_t rep_byte;
  byte_t shift_set;
  logic  cur_bit;

  assign idle_lines = item.red_level & item.white_level;

  // receive sample: both low is an error, red low is a one, else a zero
  function automatic phase_t take_phase(input logic red, input logic white);
    phase_t ph;
    if (!red && !white) begin
      ph = PH_RX_ERR;
    end else if (!red) begin
      ph = PH_RX_HOLD1;
    end else begin
      ph = PH_RX_HOLD0;
    end
    return ph;
  endfunction

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    shift_nxt  = shift_r;
    rep_valid  = 1'b0;
    rep_byte   = '0;
    rep_err    = 1'b0;
    tx_done    = 1'b0;
    tx_refused = item.op;
    shift_set  = shift_r;
    shift_set[idx_r] = 1'b1;
    case (phase_r)
      PH_RX_BIT: begin
        if (!idle_lines) begin
          phase_nxt = take_phase(item.red_level, item.white_level);
          if (item.red_level == 1'b0 && item.white_level == 1'b1) begin
            shift_nxt = shift_set;
          end
        end
      end
      PH_RX_HOLD1, PH_RX_HOLD0, PH_RX_REL: begin
        if ((phase_r == PH_RX_HOLD1 && item.red_level) ||
            (phase_r == PH_RX_HOLD0 && item.white_level)) begin
          phase_nxt = PH_RX_REL;
        end
        if (idle_lines) begin
          if (idx_r == LastBit) begin
            rep_valid = 1'b1;
            rep_byte  = shift_r;
            idx_nxt   = '0;
            phase_nxt = PH_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            phase_nxt = PH_RX_BIT;
          end
        end
      end
      PH_RX_ERR: begin
        if (idle_lines) begin
          rep_valid = 1'b1;
          rep_byte  = ErrByte;
          rep_err   = 1'b1;
          idx_nxt   = '0;
          phase_nxt = PH_IDLE;
        end
      end
      PH_TX_DRIVE: begin
        // receiver acknowledges on the other line
        if (shift_r[idx_r] ? !item.white_level : !item.red_level) begin
          phase_nxt = PH_TX_REL;
        end
      end
      PH_TX_REL: begin
        if (idle_lines) begin
          if (idx_r == LastBit) begin
            tx_done   = 1'b1;
            idx_nxt   = '0;
            phase_nxt = PH_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            phase_nxt = PH_TX_DRIVE;
          end
        end
      end
      default: begin
        phase_nxt  = PH_IDLE;
        tx_refused = item.op & ~idle_lines;
        if (item.op) begin
          if (idle_lines) begin
            shift_nxt = item.send_byte;
            idx_nxt   = '0;
            phase_nxt = PH_TX_DRIVE;
          end
        end else if (!idle_lines) begin
          idx_nxt   = '0;
          shift_nxt = {{(ByteW-1){1'b0}}, ~item.red_level & item.white_level};
          phase_nxt = take_phase(item.red_level, item.white_level);
        end
      end
    endcase
  end

  // outputs, driven from the updated state
  assign cur_bit = shift_nxt[idx_nxt];

  always_comb begin
    res            = '0;
    res.rx_valid   = rep_valid;
    res.rx_byte    = rep_byte;
    res.rx_error   = rep_err;
    res.tx_done    = tx_done;
    res.tx_refused = tx_refused;
    res.busy_res   = (phase_nxt != PH_IDLE);
    case (phase_nxt)
      PH_TX_DRIVE: begin
        res.pull_red   = cur_bit;
        res.pull_white = ~cur_bit;
      end
      PH_RX_HOLD1: res.pull_white = ~spy_only;
      PH_RX_HOLD0: res.pull_red   = ~spy_only;
      default: begin
        res.pull_red   = 1'b0;
        res.pull_white = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      shift_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

>>> rtl/two_wire_handshake_link_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_handshake_link_unit: two-wire handshake byte link
// Red/white open-drain byte link, lsb first, full per-bit handshake.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        carries
//  in_ch     in    valid/ready      op, send_byte, red_level, white_level
//  out_ch    out   valid/ready      line pulls, rx byte/error, tx status
//  cfg_*     in    write enable     spy_only
//
//  One request in, one result out; a new request is taken every cycle
//  while out_ch is not stalled. Two register stages: input register, then
//  the state machine step into the result register, which holds each
//  result. Synchronous active-low reset clears state to idle and
//  spy_only to 0. A stalled result holds and the input register fills;
//  in_ch.ready drops only when both stages are occupied and out_ch stalls.
// ----------------------------------------------------------------------------
module two_wire_handshake_link_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  tlink_in_if.sink   in_ch,
  tlink_out_if.source out_ch
);
  import tlink_pkg::*;

  logic      spy_r;
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t step_res;
  logic      advance;

  assign advance     = in_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spy_r <= 1'b0;
    end else if (cfg_we) begin
      spy_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.op          <= in_ch.op;
      in_item_r.send_byte   <= in_ch.send_byte;
      in_item_r.red_level   <= in_ch.red_level;
      in_item_r.white_level <= in_ch.white_level;
    end
  end

  tlink_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .spy_only (spy_r),
    .item     (in_item_r),
    .res      (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= step_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pull_red   = out_item_r.pull_red;
  assign out_ch.pull_white = out_item_r.pull_white;
  assign out_ch.rx_valid   = out_item_r.rx_valid;
  assign out_ch.rx_byte    = out_item_r.rx_byte;
  assign out_ch.rx_error   = out_item_r.rx_error;
  assign out_ch.tx_done    = out_item_r.tx_done;
  assign out_ch.tx_refused = out_item_r.tx_refused;
  assign out_ch.busy_res   = out_item_r.busy_res;

endmodule

>>> verif/link_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_checker: result checker for the two-wire handshake link
// Runs every accepted request through its own copy of the red/white
// handshake machine and compares each accepted result, field by field,
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module link_checker (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  tlink_in_if   in_mon,
  tlink_out_if  out_mon,
  output int    fail_count,
  output int    pending
);
  import tlink_pkg::*;

  phase_t    ph;
  bit_idx_t  bidx;
  byte_t     shreg;
  logic      spy;
  out_item_t link_res;
  out_item_t line_results [$];
  out_item_t want;
  out_item_t got;
  in_item_t  req;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // line sample while waiting for a bit: error, a one or a zero
  task take_sample(input logic red, input logic white);
    if (!red && !white) begin
      ph = PH_RX_ERR;
    end else if (!red) begin
      shreg[bidx] = 1'b1;
      ph = PH_RX_HOLD1;
    end else begin
      ph = PH_RX_HOLD0;
    end
  endtask

  // both lines back high after a received bit
  task close_bit;
    if (bidx == LastBit) begin
      link_res.rx_valid = 1'b1;
      link_res.rx_byte  = shreg;
      bidx = '0;
      ph = PH_IDLE;
    end else begin
      bidx = bidx + 1'b1;
      ph = PH_RX_BIT;
    end
  endtask

  task step_link(input in_item_t smp);
    logic lines_idle;
    logic send_left;
    lines_idle = smp.red_level & smp.white_level;
    send_left  = smp.op;
    link_res   = '0;
    case (ph)
      PH_RX_BIT: begin
        if (!lines_idle) take_sample(smp.red_level, smp.white_level);
      end
      PH_RX_HOLD1: begin
        if (smp.red_level) begin
          ph = PH_RX_REL;
          if (lines_idle) close_bit();
        end
      end
      PH_RX_HOLD0: begin
        if (smp.white_level) begin
          ph = PH_RX_REL;
          if (lines_idle) close_bit();
        end
      end
      PH_RX_REL: begin
        if (lines_idle) close_bit();
      end
      PH_RX_ERR: begin
        if (lines_idle) begin
          link_res.rx_valid = 1'b1;
          link_res.rx_byte  = ErrByte;
          link_res.rx_error = 1'b1;
          bidx = '0;
          ph = PH_IDLE;
        end
      end
      PH_TX_DRIVE: begin
        // wait for the ack on the line we are not pulling
        if (shreg[bidx] ? !smp.white_level : !smp.red_level) ph = PH_TX_REL;
      end
      PH_TX_REL: begin
        if (lines_idle) begin
          if (bidx == LastBit) begin
            link_res.tx_done = 1'b1;
            bidx = '0;
            ph = PH_IDLE;
          end else begin
            bidx = bidx + 1'b1;
            ph = PH_TX_DRIVE;
          end
        end
      end
      default: begin
        ph = PH_IDLE;
        if (smp.op) begin
          if (lines_idle) begin
            shreg = smp.send_byte;
            bidx = '0;
            ph = PH_TX_DRIVE;
          end else begin
            link_res.tx_refused = 1'b1;
          end
        end else if (!lines_idle) begin
          shreg = '0;
          bidx = '0;
          take_sample(smp.red_level, smp.white_level);
        end
        send_left = 1'b0;
      end
    endcase

    // a send request that arrives mid-transfer is dropped
    if (send_left) link_res.tx_refused = 1'b1;

    case (ph)
      PH_TX_DRIVE: begin
        if (shreg[bidx]) link_res.pull_red = 1'b1;
        else link_res.pull_white = 1'b1;
      end
      PH_RX_HOLD1: link_res.pull_white = !spy;
      PH_RX_HOLD0: link_res.pull_red = !spy;
      default: ;
    endcase
    link_res.busy_res = (ph != PH_IDLE);
  endtask

  task check_field(input string fname, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph    = PH_IDLE;
      bidx  = '0;
      shreg = '0;
      spy   = 1'b0;
      line_results.delete();
    end else begin
      if (cfg_we) spy = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        req.op          = in_mon.op;
        req.send_byte   = in_mon.send_byte;
        req.red_level   = in_mon.red_level;
        req.white_level = in_mon.white_level;
        step_link(req);
        line_results.push_back(link_res);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.pull_red   = out_mon.pull_red;
        got.pull_white = out_mon.pull_white;
        got.rx_valid   = out_mon.rx_valid;
        got.rx_byte    = out_mon.rx_byte;
        got.rx_error   = out_mon.rx_error;
        got.tx_done    = out_mon.tx_done;
        got.tx_refused = out_mon.tx_refused;
        got.busy_res   = out_mon.busy_res;
        if (line_results.size() == 0) begin
          $display("%0t: result %0h expected none actual %0h", $time, got, got);
          fail_count++;
        end else begin
          want = line_results.pop_front();
          check_field("pull_red", want.pull_red, got.pull_red);
          check_field("pull_white", want.pull_white, got.pull_white);
          check_field("rx_valid", want.rx_valid, got.rx_valid);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("rx_error", want.rx_error, got.rx_error);
          check_field("tx_done", want.tx_done, got.tx_done);
          check_field("tx_refused", want.tx_refused, got.tx_refused);
          check_field("busy_res", want.busy_res, got.busy_res);
        end
      end
    end
    pending <= line_results.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: two-wire handshake link top level
// Plays the far end of the red/white wires: well-formed byte receives and
// sends with random timing, broken receives, refused sends and line noise,
// under both spy settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import tlink_pkg::*;

  localparam int WatchLimit  = 1000;
  localparam int LinkLatency = 2;
  localparam int PhaseItems  = 90;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic quiet;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   item_cnt;

  tlink_in_if  in_ch ();
  tlink_out_if out_ch ();

  two_wire_handshake_link_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  link_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (quiet || sel < 65) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic byte_t pick_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic logic busy_op();
    return ($urandom_range(0, 15) == 0);
  endfunction

  task automatic put_sample(input logic op, input byte_t val, input logic red,
                            input logic white);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.send_byte   <= op ? val : byte_t'($urandom_range(0, 255));
    in_ch.red_level   <= red;
    in_ch.white_level <= white;
    item_cnt++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LinkLatency) @(posedge clk);
  endtask

  task automatic write_spy(input logic v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // both-low then idle pairs: any transfer in progress ends within nine
  task automatic line_flush();
    repeat (9) begin
      put_sample(1'b0, 8'h00, 1'b0, 1'b0);
      put_sample(1'b0, 8'h00, 1'b1, 1'b1);
    end
  endtask

  // far end sends val to the block, optionally breaking off with both low
  task automatic recv_byte(input byte_t val, input logic broken);
    int cut;
    cut = broken ? $urandom_range(0, 7) : 8;
    for (int i = 0; i < 8; i++) begin
      repeat ($urandom_range(0, 2)) put_sample(1'b0, 8'h00, 1'b1, 1'b1);
      if (i == cut) begin
        put_sample(1'b0, 8'h00, 1'b0, 1'b0);
        repeat ($urandom_range(0, 3))
          put_sample(busy_op(), pick_byte(), 1'b0, 1'($urandom_range(0, 1)));
        put_sample(1'b0, 8'h00, 1'b1, 1'b1);
        return;
      end
      repeat ($urandom_range(1, 2)) put_sample(1'b0, 8'h00, !val[i], val[i]);
      // ack seen on the wire, then the far end lets go of its line
      repeat ($urandom_range(0, 3)) put_sample(busy_op(), pick_byte(), 1'b0, 1'b0);
      repeat ($urandom_range(0, 2)) put_sample(busy_op(), pick_byte(), val[i], !val[i]);
      put_sample(1'b0, 8'h00, 1'b1, 1'b1);
    end
  endtask

  // block sends val, far end acknowledges every bit
  task automatic send_byte_seq(input byte_t val);
    if ($urandom_range(0, 9) == 0)
      put_sample(1'b1, pick_byte(), 1'b0, 1'($urandom_range(0, 1)));
    put_sample(1'b1, val, 1'b1, 1'b1);
    for (int i = 0; i < 8; i++) begin
      repeat ($urandom_range(0, 2)) put_sample(busy_op(), pick_byte(), !val[i], val[i]);
      repeat ($urandom_range(1, 2)) put_sample(busy_op(), pick_byte(), 1'b0, 1'b0);
      repeat ($urandom_range(0, 2)) put_sample(busy_op(), pick_byte(), val[i], !val[i]);
      put_sample(1'b0, 8'h00, 1'b1, 1'b1);
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      put_sample(1'($urandom_range(0, 1)), pick_byte(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    line_flush();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
      @(posedge clk);
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("two_wire_handshake_link_unit test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int sel;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    quiet             = 1'b0;
    item_cnt          = 0;
    in_ch.valid       = 1'b0;
    in_ch.op          = 1'b0;
    in_ch.send_byte   = 8'h00;
    in_ch.red_level   = 1'b1;
    in_ch.white_level = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_spy(1'b0);

    put_sample(1'b0, 8'h00, 1'b1, 1'b1);
    put_sample(1'b1, 8'hFF, 1'b0, 1'b1);   // send refused, lines busy
    put_sample(1'b1, 8'h00, 1'b1, 1'b0);
    put_sample(1'b1, 8'h5A, 1'b0, 1'b0);
    put_sample(1'b0, 8'h00, 1'b0, 1'b0);   // receive opens with both low
    put_sample(1'b1, 8'hA5, 1'b1, 1'b0);   // send refused, block busy
    put_sample(1'b0, 8'h00, 1'b1, 1'b1);
    put_sample(1'b0, 8'h00, 1'b0, 1'b1);
    put_sample(1'b0, 8'h00, 1'b0, 1'b0);
    write_spy(1'b1);                       // spy switched mid-receive
    put_sample(1'b0, 8'h00, 1'b0, 1'b0);
    put_sample(1'b1, 8'hC3, 1'b1, 1'b1);   // release and bit end together
    put_sample(1'b0, 8'h00, 1'b1, 1'b1);
    put_sample(1'b0, 8'h00, 1'b1, 1'b0);
    write_spy(1'b0);
    put_sample(1'b0, 8'h00, 1'b1, 1'b0);
    put_sample(1'b0, 8'h00, 1'b1, 1'b1);
    put_sample(1'b0, 8'h00, 1'b0, 1'b0);   // both low while waiting for a bit
    put_sample(1'b0, 8'h00, 1'b1, 1'b1);

    for (int p = 0; p < 4; p++) begin
      write_spy(p[0]);
      quiet = (p == 2);
      item_cnt = 0;
      while (item_cnt < PhaseItems) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) recv_byte(pick_byte(), $urandom_range(0, 9) == 0);
        else if (sel < 80) send_byte_seq(pick_byte());
        else noise_burst();
        repeat ($urandom_range(1, 3)) put_sample(1'b0, 8'h00, 1'b1, 1'b1);
      end
    end

    drain_results();
    if (fail_count == 0)
      $display("two_wire_handshake_link_unit test passed");
    else
      $display("two_wire_handshake_link_unit test failed");
    $finish;
  end

endmodule

>>> two_wire_handshake_link_unit.f
rtl/tlink_pkg.sv
rtl/tlink_in_if.sv
rtl/tlink_out_if.sv
rtl/tlink_core.sv
rtl/two_wire_handshake_link_unit.sv
verif/link_checker.sv
verif/testbench.sv
